FILE: hdl/lob_pkg.sv
// Shared types and constants of the limit order matching book.
`default_nettype none
package lob_pkg;
  localparam int BookDepth = 64;
  localparam int ResultCap = 64;
  localparam int CntW = $clog2(ResultCap + 1);

  localparam logic [1:0] OutFilled   = 2'd0;
  localparam logic [1:0] OutRested   = 2'd1;
  localparam logic [1:0] OutRejected = 2'd2;

  typedef struct packed {
    logic        valid;
    logic [31:0] price;
    logic [31:0] rem;
    logic [31:0] ident;
  } entry_t;

  typedef enum logic [1:0] {
    BK_HOLD,
    BK_DEC,
    BK_POP,
    BK_INS
  } book_op_e;

  typedef struct packed {
    book_op_e    op;
    logic        is_bid;
    entry_t      ins;
    logic [31:0] dec;
  } book_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_PLACE,
    ST_FIN
  } state_e;
endpackage
`default_nettype wire

FILE: hdl/lob_cell.sv
// One book slot: holds an order and trades places with its neighbors.
`default_nettype none
module lob_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               first_i,
  input  wire lob_pkg::book_ctrl_t ctrl_i,
  input  wire lob_pkg::entry_t    prev_i,
  input  wire logic               prev_after_i,
  input  wire lob_pkg::entry_t    next_i,
  output lob_pkg::entry_t         ent_o,
  output logic                    after_o
);
  lob_pkg::entry_t ent_q, ent_d;
  logic            vld_q;

  // The new order goes behind every valid entry that is at least as good.
  assign after_o = vld_q && (ctrl_i.is_bid ? (ent_q.price >= ctrl_i.ins.price)
                                           : (ent_q.price <= ctrl_i.ins.price));

  always_comb begin
    ent_d = ent_q;
    ent_d.valid = vld_q;
    unique case (ctrl_i.op)
      lob_pkg::BK_DEC: begin
        if (first_i) ent_d.rem = ent_q.rem - ctrl_i.dec;
      end
      lob_pkg::BK_POP: ent_d = next_i;
      lob_pkg::BK_INS: begin
        if (!after_o) ent_d = prev_after_i ? ctrl_i.ins : prev_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ent_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  always_comb begin
    ent_o = ent_q;
    ent_o.valid = vld_q;
  end
endmodule
`default_nettype wire

FILE: hdl/lob_book.sv
// One side of the book: a row of cells kept in priority order.
`default_nettype none
module lob_book (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lob_pkg::book_ctrl_t ctrl_i,
  output lob_pkg::entry_t          head_o,
  output logic                     full_o
);
  lob_pkg::entry_t ent [lob_pkg::BookDepth];
  logic            aft [lob_pkg::BookDepth];

  for (genvar i = 0; i < lob_pkg::BookDepth; i++) begin : g_cell
    lob_pkg::entry_t prev, next;
    logic            prev_after;
    if (i == 0) begin : g_first
      assign prev = '0;
      assign prev_after = 1'b1;
    end else begin : g_mid
      assign prev = ent[i-1];
      assign prev_after = aft[i-1];
    end
    if (i == lob_pkg::BookDepth - 1) begin : g_last
      assign next = '0;
    end else begin : g_nx
      assign next = ent[i+1];
    end
    lob_cell u_cell (
      .clk_i, .rst_ni,
      .first_i(i == 0),
      .ctrl_i,
      .prev_i(prev),
      .prev_after_i(prev_after),
      .next_i(next),
      .ent_o(ent[i]),
      .after_o(aft[i])
    );
  end

  assign head_o = ent[0];
  assign full_o = ent[lob_pkg::BookDepth-1].valid;
endmodule
`default_nettype wire

FILE: hdl/limit_order_matching_book.sv
// Top level: order intake, matching sequencer and result register.
// An order with no trade passes through the match, place and finish steps to its result.
// Each trade is one pass of the match loop against the head cell, which waits while the
// output is busy; the place step then puts any remainder in by a single shift of the cell row.
// The finish step sends the last beat; the next order is not taken until that beat is issued.
// Reset empties both books at once through the cell valid flags.
`default_nettype none
module limit_order_matching_book (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [95:0]  s_axis_tdata_i,  // limit_price, quantity, ident
  input  wire logic         s_axis_tuser_i,  // side
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [103:0]      m_axis_tdata_o,  // buyer_id, seller_id, traded_units, outcome, 6'b0
  output logic              m_axis_tuser_o,  // has_trade
  output logic              m_axis_tlast_o
);
  typedef struct packed {
    logic [31:0] buyer;
    logic [31:0] seller;
    logic [31:0] units;
  } trade_t;

  lob_pkg::state_e     st_q, st_d;
  logic                side_q, side_d;
  logic [31:0]         price_q, price_d, rem_q, rem_d, id_q, id_d;
  logic [lob_pkg::CntW-1:0] k_q, k_d;
  trade_t              pend_q, pend_d, trd;
  logic                pend_vld_q, pend_vld_d;
  logic [1:0]          outc_q, outc_d;
  logic                mv_q, mv_d, mlast_q, mlast_d, muser_q, muser_d;
  logic [103:0]        mdata_q, mdata_d;
  lob_pkg::book_ctrl_t bid_ctrl, ask_ctrl, opp_ctrl, own_ctrl;
  lob_pkg::entry_t     bid_head, ask_head, head;
  logic                bid_full, ask_full, own_full, crossing, out_free;
  logic [31:0]         t;

  lob_book u_bid (.clk_i, .rst_ni, .ctrl_i(bid_ctrl), .head_o(bid_head), .full_o(bid_full));
  lob_book u_ask (.clk_i, .rst_ni, .ctrl_i(ask_ctrl), .head_o(ask_head), .full_o(ask_full));

  assign head     = side_q ? bid_head : ask_head;
  assign own_full = side_q ? ask_full : bid_full;
  assign out_free = !mv_q || m_axis_tready_i;
  assign crossing = head.valid && (rem_q != 32'd0)
                    && (k_q < lob_pkg::CntW'(lob_pkg::ResultCap))
                    && (side_q ? (head.price >= price_q) : (price_q >= head.price));
  assign t        = (rem_q < head.rem) ? rem_q : head.rem;
  assign trd.buyer  = side_q ? head.ident : id_q;
  assign trd.seller = side_q ? id_q : head.ident;
  assign trd.units  = t;

  always_comb begin
    st_d = st_q; side_d = side_q; price_d = price_q; rem_d = rem_q; id_d = id_q;
    k_d = k_q; pend_d = pend_q; pend_vld_d = pend_vld_q; outc_d = outc_q;
    mv_d = mv_q && !m_axis_tready_i; mlast_d = mlast_q; muser_d = muser_q; mdata_d = mdata_q;
    opp_ctrl = '{op: lob_pkg::BK_HOLD, is_bid: side_q, ins: '0, dec: t};
    own_ctrl = '{op: lob_pkg::BK_HOLD, is_bid: !side_q,
                 ins: '{valid: 1'b1, price: price_q, rem: rem_q, ident: id_q}, dec: '0};
    s_axis_tready_o = 1'b0;
    unique case (st_q)
      lob_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          side_d = s_axis_tuser_i;
          price_d = s_axis_tdata_i[31:0];
          rem_d = s_axis_tdata_i[63:32];
          id_d = s_axis_tdata_i[95:64];
          k_d = '0;
          pend_vld_d = 1'b0;
          st_d = lob_pkg::ST_MATCH;
        end
      end
      lob_pkg::ST_MATCH: begin
        if (!crossing) begin
          st_d = lob_pkg::ST_PLACE;
        end else if (out_free) begin
          if (pend_vld_q) begin
            mv_d = 1'b1; mlast_d = 1'b0; muser_d = 1'b1;
            mdata_d = {6'd0, lob_pkg::OutFilled, pend_q.units, pend_q.seller, pend_q.buyer};
          end
          pend_d = trd;
          pend_vld_d = 1'b1;
          rem_d = rem_q - t;
          k_d = k_q + 1'b1;
          opp_ctrl.op = (head.rem == t) ? lob_pkg::BK_POP : lob_pkg::BK_DEC;
        end
      end
      lob_pkg::ST_PLACE: begin
        if (rem_q == 32'd0) begin
          outc_d = lob_pkg::OutFilled;
        end else if (own_full) begin
          outc_d = lob_pkg::OutRejected;
        end else begin
          outc_d = lob_pkg::OutRested;
          own_ctrl.op = lob_pkg::BK_INS;
        end
        st_d = lob_pkg::ST_FIN;
      end
      lob_pkg::ST_FIN: begin
        if (out_free) begin
          mv_d = 1'b1; mlast_d = 1'b1; muser_d = pend_vld_q;
          mdata_d = pend_vld_q ? {6'd0, outc_q, pend_q.units, pend_q.seller, pend_q.buyer}
                               : {6'd0, outc_q, 96'd0};
          st_d = lob_pkg::ST_IDLE;
        end
      end
      default: st_d = lob_pkg::ST_IDLE;
    endcase
    bid_ctrl = side_q ? opp_ctrl : own_ctrl;
    ask_ctrl = side_q ? own_ctrl : opp_ctrl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= lob_pkg::ST_IDLE;
      mv_q <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      mv_q <= mv_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    side_q <= side_d; price_q <= price_d; rem_q <= rem_d; id_q <= id_d; k_q <= k_d;
    pend_q <= pend_d; outc_q <= outc_d; mlast_q <= mlast_d; muser_q <= muser_d;
    mdata_q <= mdata_d;
  end

  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = mdata_q;
  assign m_axis_tuser_o  = muser_q;
  assign m_axis_tlast_o  = mlast_q;

  a_acc_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (st_q == lob_pkg::ST_MATCH))
    else $error("accepted order did not start matching");
  a_trade_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[95:64] != 32'd0))
    else $error("trade beat with zero units");
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bid_head.valid || !bid_full) && (ask_head.valid || !ask_full))
    else $error("book valid entries are not a prefix");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != lob_pkg::ST_IDLE) |-> (k_q <= lob_pkg::CntW'(lob_pkg::ResultCap)))
    else $error("trade count exceeded cap");
endmodule
`default_nettype wire
